>>> rtl/bmf4_pkg.sv
// Shared types and constants for the 4D box mean filter.
// No dependencies; every other file in rtl/ imports this package.
package bmf4_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MEAN_W     = 24;
    localparam int WCNT_W     = 20;   // 31^4 window samples fit in 20 bits
    localparam int SUM_W      = SAMPLE_W + WCNT_W;
    localparam int RAD_W      = 4;
    localparam int SXY_W      = 11;
    localparam int SZT_W      = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;
    localparam int WIN_W      = 5;    // window step counter, 0..30

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_T = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_T   = 4'd7;

    localparam logic [SXY_W-1:0] MAX_SIZE_XY = 11'd1024;
    localparam logic [SZT_W-1:0] MAX_SIZE_ZT = 9'd256;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
    } bmf4_in_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              is_border;
        logic              span_error;
        logic              last;
    } bmf4_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bmf4_div_stat_t;

    typedef enum logic [4:0] {
        ST_SETUP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } bmf4_state_t;

endpackage

>>> rtl/bmf4_store.sv
// Sample ring store: one write port, one read port, registered read data.
// Depends on bmf4_pkg for the sample width.
module bmf4_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [bmf4_pkg::SAMPLE_W-1:0] wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [bmf4_pkg::SAMPLE_W-1:0] rdata
);
    import bmf4_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bmf4_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bmf4_pkg for the status struct.
module bmf4_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NUM_W-1:0]             numer,
    input  logic [DEN_W-1:0]             denom,
    output bmf4_pkg::bmf4_div_stat_t     stat,
    output logic [NUM_W-1:0]             quot
);
    import bmf4_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    // one shift-subtract step
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = numer;
            den_next  = denom;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule

>>> rtl/box_mean_filter_4d_top.sv
// Streaming 4D box mean filter: top level with control, setup and window scan.
// Depends on bmf4_pkg, bmf4_store and bmf4_div.
//
// Samples arrive channel fastest, then t, z, y, x, and are written into a ring
// store. Each result lags the input by the half-span D and is the Q16.8 mean of
// its channel's window; border voxels and a window span beyond the store give
// zero. The final D results come out on drain transactions. One transaction
// is handled at a time: one that gives no result ends at accept, a border or
// span-error result passes accept and output load, and an interior one adds
// one store read per window sample on the single read port, then read drain,
// divider start, the bit-serial divider and output load. A result held by the
// receiver stalls the next result, and with it the input. After reset and
// after every configuration write a setup sequence computes strides, image
// size and window count; no sample is taken then.
// The store has no clearing pass.
module box_mean_filter_4d_top #(
    parameter int CHANNELS     = 1,
    parameter int WINDOW_DEPTH = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bmf4_pkg::bmf4_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bmf4_pkg::bmf4_out_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bmf4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmf4_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bmf4_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int POS_W = 41 + $clog2(CHANNELS);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NUM_W = SUM_W + 8;
    localparam logic [AW:0] WD_L = (AW + 1)'(WINDOW_DEPTH);

    // ring address add, both operands below the depth
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
                                               input logic [AW-1:0] s);
        logic [AW:0] t;
        t = {1'b0, p} + {1'b0, s};
        if (t >= WD_L)
        begin
            t = t - WD_L;
        end
        return t[AW-1:0];
    endfunction

    // configuration registers
    logic [RAD_W-1:0] rx_reg, ry_reg, rz_reg, rt_reg;
    logic [SXY_W-1:0] size_x_reg, size_y_reg;
    logic [SZT_W-1:0] size_z_reg, size_t_reg;
    logic [SXY_W-1:0] sx_c, sy_c;
    logic [SZT_W-1:0] sz_c, st_c;

    // setup results
    logic [POS_W-1:0]  str_z_reg, str_y_reg, str_x_reg, n_reg, d_reg;
    logic [WCNT_W-1:0] wcnt_reg;
    logic              err_reg;
    logic [2:0]        step_reg;

    // stream positions
    logic [POS_W-1:0] ip_reg, ip_next, op_reg, op_next;
    logic [AW-1:0]    wp_reg, wp_next, opp_reg, opp_next;
    logic [CH_W-1:0]  cch_reg, cch_next;
    logic [7:0]       ct_reg, ct_next, cz_reg, cz_next;
    logic [9:0]       cy_reg, cy_next, cx_reg, cx_next;

    // scan state
    bmf4_state_t      state_reg, state_next;
    logic [WIN_W-1:0] wa_reg, wa_next, wb_reg, wb_next, wc_reg, wc_next, wd_reg, wd_next;
    logic [AW-1:0]    lx_reg, lx_next, ly_reg, ly_next, lz_reg, lz_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic             issuing_reg, issuing_next, rd_pend_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic             border_reg, border_next, last_reg, last_next;
    bmf4_out_t        out_data_reg, out_data_next;
    logic             out_valid_reg, out_valid_next;

    // datapath links
    logic                in_acc, cfg_acc, we, re, div_start, emit, border_now;
    logic [SAMPLE_W-1:0] rd_data;
    logic [NUM_W-1:0]    quot;
    bmf4_div_stat_t      div_stat;
    logic [AW:0]         base_t;
    logic [AW-1:0]       base;
    logic [AW-1:0]       new_x, new_y, new_z;
    logic [WIN_W-1:0]    ea, eb, ec, ed;

    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid;
    assign in_ready  = (state_reg == ST_IDLE);

    // clamped extents
    always_comb
    begin
        sx_c = (size_x_reg == '0) ? SXY_W'(1) :
               ((size_x_reg > MAX_SIZE_XY) ? MAX_SIZE_XY : size_x_reg);
        sy_c = (size_y_reg == '0) ? SXY_W'(1) :
               ((size_y_reg > MAX_SIZE_XY) ? MAX_SIZE_XY : size_y_reg);
        sz_c = (size_z_reg == '0) ? SZT_W'(1) :
               ((size_z_reg > MAX_SIZE_ZT) ? MAX_SIZE_ZT : size_z_reg);
        st_c = (size_t_reg == '0) ? SZT_W'(1) :
               ((size_t_reg > MAX_SIZE_ZT) ? MAX_SIZE_ZT : size_t_reg);
    end

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg     <= 4'd1;
            ry_reg     <= 4'd1;
            rz_reg     <= 4'd0;
            rt_reg     <= 4'd0;
            size_x_reg <= 11'd64;
            size_y_reg <= 11'd64;
            size_z_reg <= 9'd1;
            size_t_reg <= 9'd1;
        end
        else if (cfg_acc)
        begin
            case (cfg_index)
                REG_RADIUS_X: rx_reg     <= cfg_data[RAD_W-1:0];
                REG_RADIUS_Y: ry_reg     <= cfg_data[RAD_W-1:0];
                REG_RADIUS_Z: rz_reg     <= cfg_data[RAD_W-1:0];
                REG_RADIUS_T: rt_reg     <= cfg_data[RAD_W-1:0];
                REG_SIZE_X:   size_x_reg <= cfg_data;
                REG_SIZE_Y:   size_y_reg <= cfg_data;
                REG_SIZE_Z:   size_z_reg <= cfg_data[SZT_W-1:0];
                REG_SIZE_T:   size_t_reg <= cfg_data[SZT_W-1:0];
                default:      ;
            endcase
        end
    end

    // setup sequence: strides, image size, half-span, window count, span check
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            case (step_reg)
                3'd0: str_z_reg <= POS_W'(CHANNELS) * POS_W'(st_c);
                3'd1: str_y_reg <= str_z_reg * POS_W'(sz_c);
                3'd2: str_x_reg <= str_y_reg * POS_W'(sy_c);
                3'd3: n_reg     <= str_x_reg * POS_W'(sx_c);
                3'd4:
                begin
                    d_reg    <= POS_W'(rx_reg) * str_x_reg;
                    wcnt_reg <= WCNT_W'({rx_reg, 1'b1}) * WCNT_W'({ry_reg, 1'b1});
                end
                3'd5:
                begin
                    d_reg    <= d_reg + POS_W'(ry_reg) * str_y_reg;
                    wcnt_reg <= wcnt_reg * WCNT_W'({rz_reg, 1'b1});
                end
                3'd6:
                begin
                    d_reg    <= d_reg + POS_W'(rz_reg) * str_z_reg
                                + POS_W'(rt_reg) * POS_W'(CHANNELS);
                    wcnt_reg <= wcnt_reg * WCNT_W'({rt_reg, 1'b1});
                end
                default: err_reg <= ({d_reg, 1'b1} > (POS_W + 1)'(WINDOW_DEPTH));
            endcase
        end
    end

    // border test on the voxel about to be given out
    always_comb
    begin
        border_now = ({1'b0, cx_reg} < SXY_W'(rx_reg))
                  || ((SXY_W'(cx_reg) + SXY_W'(rx_reg)) >= sx_c)
                  || ({1'b0, cy_reg} < SXY_W'(ry_reg))
                  || ((SXY_W'(cy_reg) + SXY_W'(ry_reg)) >= sy_c)
                  || ({1'b0, cz_reg} < SZT_W'(rz_reg))
                  || ((SZT_W'(cz_reg) + SZT_W'(rz_reg)) >= sz_c)
                  || ({1'b0, ct_reg} < SZT_W'(rt_reg))
                  || ((SZT_W'(ct_reg) + SZT_W'(rt_reg)) >= st_c);
        base_t = {1'b0, opp_reg} + WD_L - {1'b0, d_reg[AW-1:0]};
        if (base_t >= WD_L)
        begin
            base_t = base_t - WD_L;
        end
        base  = base_t[AW-1:0];
        new_x = ring_add(lx_reg, str_x_reg[AW-1:0]);
        new_y = ring_add(ly_reg, str_y_reg[AW-1:0]);
        new_z = ring_add(lz_reg, str_z_reg[AW-1:0]);
        ea    = {rx_reg, 1'b0};
        eb    = {ry_reg, 1'b0};
        ec    = {rz_reg, 1'b0};
        ed    = {rt_reg, 1'b0};
    end

    // main control
    always_comb
    begin
        state_next     = state_reg;
        ip_next        = ip_reg;
        op_next        = op_reg;
        wp_next        = wp_reg;
        opp_next       = opp_reg;
        cch_next       = cch_reg;
        ct_next        = ct_reg;
        cz_next        = cz_reg;
        cy_next        = cy_reg;
        cx_next        = cx_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        wc_next        = wc_reg;
        wd_next        = wd_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        lz_next        = lz_reg;
        addr_next      = addr_reg;
        issuing_next   = issuing_reg;
        sum_next       = sum_reg;
        mean_next      = mean_reg;
        border_next    = border_reg;
        last_next      = last_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        we             = 1'b0;
        re             = 1'b0;
        div_start      = 1'b0;
        emit           = 1'b0;

        // accumulate returning read data
        if (rd_pend_reg)
        begin
            sum_next = sum_reg + SUM_W'(rd_data);
        end

        case (state_reg)
            ST_SETUP:
            begin
                if (step_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!in_data.kind)
                    begin
                        if (ip_reg < n_reg)
                        begin
                            we      = 1'b1;
                            ip_next = ip_reg + 1'b1;
                            wp_next = ring_add(wp_reg, AW'(1));
                            emit    = ((ip_reg + 1'b1) > d_reg) && (op_reg < n_reg);
                        end
                    end
                    else
                    begin
                        emit = (ip_reg >= n_reg) && (op_reg < n_reg);
                    end
                    if (emit)
                    begin
                        border_next = border_now;
                        last_next   = (op_reg == n_reg - 1'b1);
                        if (border_now || err_reg)
                        begin
                            mean_next  = '0;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            lx_next      = base;
                            ly_next      = base;
                            lz_next      = base;
                            addr_next    = base;
                            wa_next      = '0;
                            wb_next      = '0;
                            wc_next      = '0;
                            wd_next      = '0;
                            sum_next     = '0;
                            issuing_next = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (issuing_reg)
                begin
                    re = 1'b1;
                    if (wd_reg != ed)
                    begin
                        wd_next   = wd_reg + 1'b1;
                        addr_next = ring_add(addr_reg, AW'(CHANNELS));
                    end
                    else if (wc_reg != ec)
                    begin
                        wc_next   = wc_reg + 1'b1;
                        wd_next   = '0;
                        lz_next   = new_z;
                        addr_next = new_z;
                    end
                    else if (wb_reg != eb)
                    begin
                        wb_next   = wb_reg + 1'b1;
                        wc_next   = '0;
                        wd_next   = '0;
                        ly_next   = new_y;
                        lz_next   = new_y;
                        addr_next = new_y;
                    end
                    else if (wa_reg != ea)
                    begin
                        wa_next   = wa_reg + 1'b1;
                        wb_next   = '0;
                        wc_next   = '0;
                        wd_next   = '0;
                        lx_next   = new_x;
                        ly_next   = new_x;
                        lz_next   = new_x;
                        addr_next = new_x;
                    end
                    else
                    begin
                        issuing_next = 1'b0;
                    end
                end
                else if (!rd_pend_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    mean_next  = quot[MEAN_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.mean       = mean_reg;
                    out_data_next.is_border  = border_reg;
                    out_data_next.span_error = err_reg;
                    out_data_next.last       = last_reg;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                    if ((op_reg + 1'b1) >= n_reg)
                    begin
                        op_next  = '0;
                        ip_next  = '0;
                        wp_next  = '0;
                        opp_next = '0;
                        cch_next = '0;
                        ct_next  = '0;
                        cz_next  = '0;
                        cy_next  = '0;
                        cx_next  = '0;
                    end
                    else
                    begin
                        op_next  = op_reg + 1'b1;
                        opp_next = ring_add(opp_reg, AW'(1));
                        if (cch_reg != CH_W'(CHANNELS - 1))
                        begin
                            cch_next = cch_reg + 1'b1;
                        end
                        else
                        begin
                            cch_next = '0;
                            if ({1'b0, ct_reg} != st_c - 1'b1)
                            begin
                                ct_next = ct_reg + 1'b1;
                            end
                            else
                            begin
                                ct_next = '0;
                                if ({1'b0, cz_reg} != sz_c - 1'b1)
                                begin
                                    cz_next = cz_reg + 1'b1;
                                end
                                else
                                begin
                                    cz_next = '0;
                                    if ({1'b0, cy_reg} != sy_c - 1'b1)
                                    begin
                                        cy_next = cy_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        cy_next = '0;
                                        cx_next = cx_reg + 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            default: state_next = ST_SETUP;
        endcase

        // any configuration write restarts the image
        if (cfg_acc)
        begin
            state_next = ST_SETUP;
            ip_next    = '0;
            op_next    = '0;
            wp_next    = '0;
            opp_next   = '0;
            cch_next   = '0;
            ct_next    = '0;
            cz_next    = '0;
            cy_next    = '0;
            cx_next    = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SETUP;
            step_reg      <= '0;
            ip_reg        <= '0;
            op_reg        <= '0;
            wp_reg        <= '0;
            opp_reg       <= '0;
            cch_reg       <= '0;
            ct_reg        <= '0;
            cz_reg        <= '0;
            cy_reg        <= '0;
            cx_reg        <= '0;
            issuing_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= (cfg_acc || state_reg != ST_SETUP) ? 3'd0 : step_reg + 1'b1;
            ip_reg        <= ip_next;
            op_reg        <= op_next;
            wp_reg        <= wp_next;
            opp_reg       <= opp_next;
            cch_reg       <= cch_next;
            ct_reg        <= ct_next;
            cz_reg        <= cz_next;
            cy_reg        <= cy_next;
            cx_reg        <= cx_next;
            issuing_reg   <= issuing_next;
            rd_pend_reg   <= re;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wa_reg       <= wa_next;
        wb_reg       <= wb_next;
        wc_reg       <= wc_next;
        wd_reg       <= wd_next;
        lx_reg       <= lx_next;
        ly_reg       <= ly_next;
        lz_reg       <= lz_next;
        addr_reg     <= addr_next;
        sum_reg      <= sum_next;
        mean_reg     <= mean_next;
        border_reg   <= border_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    bmf4_store #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (wp_reg),
        .wdata (in_data.sample),
        .re    (re),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    bmf4_div #(
        .NUM_W (NUM_W),
        .DEN_W (WCNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer ({sum_reg, 8'd0}),
        .denom (wcnt_reg),
        .stat  (div_stat),
        .quot  (quot)
    );

    // store writes only while the image still takes samples
    a_write_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (ip_reg < n_reg))
        else $error("store write past end of image");

    // divider is never restarted while working
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a result is only loaded when the output slot is free or being taken
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && !out_ready) |=> (state_reg == ST_OUT))
        else $error("pending result overwritten");

endmodule
